// ----- rtl/core/dsb_pkg.sv -----
// Shared types, opcode codes and helpers for the dual-stack bundle processor.
// Used by dsb_front, dsb_back, dual_stack_bundle_cpu_unit and the testbench files.
package dsb_pkg;

   localparam int MEM_WORDS_DEF  = 65536;
   localparam int DATA_DEPTH_DEF = 256;
   localparam int RET_DEPTH_DEF  = 256;

   localparam logic [7:0] OP_LIT    = 8'd1;
   localparam logic [7:0] OP_DUP    = 8'd2;
   localparam logic [7:0] OP_DROP   = 8'd3;
   localparam logic [7:0] OP_SWAP   = 8'd4;
   localparam logic [7:0] OP_PUSH   = 8'd5;
   localparam logic [7:0] OP_POP    = 8'd6;
   localparam logic [7:0] OP_JUMP   = 8'd7;
   localparam logic [7:0] OP_CALL   = 8'd8;
   localparam logic [7:0] OP_CCALL  = 8'd9;
   localparam logic [7:0] OP_RET    = 8'd10;
   localparam logic [7:0] OP_EQ     = 8'd11;
   localparam logic [7:0] OP_NEQ    = 8'd12;
   localparam logic [7:0] OP_LT     = 8'd13;
   localparam logic [7:0] OP_GT     = 8'd14;
   localparam logic [7:0] OP_FETCH  = 8'd15;
   localparam logic [7:0] OP_STORE  = 8'd16;
   localparam logic [7:0] OP_ADD    = 8'd17;
   localparam logic [7:0] OP_SUB    = 8'd18;
   localparam logic [7:0] OP_MUL    = 8'd19;
   localparam logic [7:0] OP_DIVMOD = 8'd20;
   localparam logic [7:0] OP_AND    = 8'd21;
   localparam logic [7:0] OP_OR     = 8'd22;
   localparam logic [7:0] OP_XOR    = 8'd23;
   localparam logic [7:0] OP_SHIFT  = 8'd24;
   localparam logic [7:0] OP_ZRET   = 8'd25;
   localparam logic [7:0] OP_HALT   = 8'd26;
   localparam logic [7:0] OP_IOENUM = 8'd27;
   localparam logic [7:0] OP_IOQRY  = 8'd28;
   localparam logic [7:0] OP_IOACT  = 8'd29;

   typedef enum logic [1:0] {
      KIND_LOAD,
      KIND_START,
      KIND_EXEC,
      KIND_NONE
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [15:0] addr;
      logic [31:0] value;
      logic [7:0]  in_char;
      logic        in_eof;
   } cmd_type;

   typedef struct packed {
      logic [7:0]  out_char;
      logic        out_valid;
      logic        in_taken;
      logic        halted;
      logic [16:0] pc;
   } rsp_type;

   function automatic logic [16:0] pc_clamp(input logic [31:0] ip);
      logic [16:0] r;
      if (ip[31]) begin
         r = '0;
      end else if (ip > 32'h0001_0000) begin
         r = 17'h1_0000;
      end else begin
         r = ip[16:0];
      end
      return r;
   endfunction

endpackage

// ----- rtl/core/dsb_front.sv -----
// Front end: a two-entry request queue that classifies each request by mode.
// Depends on dsb_pkg for the command type and kind codes.
module dsb_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  logic             hold,
   input  logic [1:0]       mode,
   input  logic [15:0]      addr,
   input  logic [31:0]      value,
   input  logic [7:0]       in_char,
   input  logic             in_eof,
   output logic             cmd_valid,
   output dsb_pkg::cmd_type cmd,
   input  logic             cmd_pop
);

   dsb_pkg::cmd_type q_ff [2];
   logic             wp_ff;
   logic             rp_ff;
   logic [1:0]       cnt_ff;
   dsb_pkg::cmd_type cls_in;
   logic             accept;

   always_comb begin
      cls_in.addr    = addr;
      cls_in.value   = value;
      cls_in.in_char = in_char;
      cls_in.in_eof  = in_eof;
      case (mode)
         2'd0:    cls_in.kind = dsb_pkg::KIND_LOAD;
         2'd1:    cls_in.kind = dsb_pkg::KIND_START;
         2'd2:    cls_in.kind = dsb_pkg::KIND_EXEC;
         default: cls_in.kind = dsb_pkg::KIND_NONE;
      endcase
   end

   assign full      = hold || (cnt_ff == 2'd2);
   assign accept    = push && !full;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd       = q_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (accept) begin
         q_ff[wp_ff] <= cls_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (accept) begin
            wp_ff <= ~wp_ff;
         end
         if (cmd_pop && cmd_valid) begin
            rp_ff <= ~rp_ff;
         end
         case ({accept, cmd_pop && cmd_valid})
            2'b10:   cnt_ff <= cnt_ff + 2'd1;
            2'b01:   cnt_ff <= cnt_ff - 2'd1;
            default: cnt_ff <= cnt_ff;
         endcase
      end
   end

endmodule

// ----- rtl/core/dsb_divider.sv -----
// Iterative signed divider, one quotient bit per cycle, truncating to zero.
// Standalone; used by dsb_back for the divmod opcode.
module dsb_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [31:0] quotient,
   output logic [31:0] remainder
);

   logic        busy_ff;
   logic        done_ff;
   logic [5:0]  cnt_ff;
   logic [31:0] q_ff;
   logic [31:0] r_ff;
   logic [31:0] dv_ff;
   logic        nq_ff;
   logic        nr_ff;
   logic [32:0] trial;
   logic        fits;

   assign trial = {r_ff, q_ff[31]};
   assign fits  = (trial >= {1'b0, dv_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 6'd32;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         q_ff  <= dividend[31] ? (32'd0 - dividend) : dividend;
         dv_ff <= divisor[31] ? (32'd0 - divisor) : divisor;
         r_ff  <= '0;
         nq_ff <= dividend[31] ^ divisor[31];
         nr_ff <= dividend[31];
      end else if (busy_ff) begin
         q_ff <= {q_ff[30:0], fits};
         r_ff <= fits ? 32'(trial - {1'b0, dv_ff}) : trial[31:0];
      end
   end

   assign done      = done_ff;
   assign quotient  = nq_ff ? (32'd0 - q_ff) : q_ff;
   assign remainder = nr_ff ? (32'd0 - r_ff) : r_ff;

endmodule

// ----- rtl/core/dsb_back.sv -----
// Back end: image memory, both stacks, pointers and the slot sequencer.
// Depends on dsb_pkg and instantiates dsb_divider.
module dsb_back #(
   parameter int MEM_WORDS  = dsb_pkg::MEM_WORDS_DEF,
   parameter int DATA_DEPTH = dsb_pkg::DATA_DEPTH_DEF,
   parameter int RET_DEPTH  = dsb_pkg::RET_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   input  dsb_pkg::cmd_type cmd,
   output logic             cmd_pop,
   input  logic             rsp_space,
   output logic             rsp_push,
   output dsb_pkg::rsp_type rsp,
   output logic             clearing
);

   localparam int AW = $clog2(MEM_WORDS);
   localparam int DW = $clog2(DATA_DEPTH);
   localparam int RW = $clog2(RET_DEPTH);
   localparam int CLR_A = (MEM_WORDS > DATA_DEPTH) ? MEM_WORDS : DATA_DEPTH;
   localparam int CLR_N = (CLR_A > RET_DEPTH) ? CLR_A : RET_DEPTH;
   localparam int CW = $clog2(CLR_N);
   localparam logic [31:0]   MW    = 32'(MEM_WORDS);
   localparam logic [DW-1:0] DLAST = DW'(DATA_DEPTH - 1);
   localparam logic [RW-1:0] RLAST = RW'(RET_DEPTH - 1);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_DISP, S_RD, S_DIV, S_EXEC,
      S_WR0, S_WR1, S_ADV, S_FETCH, S_EMIT
   } state_type;

   typedef struct packed {
      logic          w0_en;
      logic [DW-1:0] w0_a;
      logic [31:0]   w0_d;
      logic          w1_en;
      logic [DW-1:0] w1_a;
      logic [31:0]   w1_d;
      logic          rw_en;
      logic [RW-1:0] rw_a;
      logic [31:0]   rw_d;
      logic          mw_en;
      logic [AW-1:0] mw_a;
      logic [31:0]   mw_d;
      logic [DW-1:0] dti;
      logic [RW-1:0] rti;
      logic [31:0]   ip;
      logic [7:0]    oc;
      logic          ov;
      logic          it;
      logic          eof;
   } plan_type;

   function automatic logic [DW-1:0] dinc(input logic [DW-1:0] x);
      return (x == DLAST) ? '0 : x + 1'b1;
   endfunction
   function automatic logic [DW-1:0] ddec(input logic [DW-1:0] x);
      return (x == '0) ? DLAST : x - 1'b1;
   endfunction
   function automatic logic [RW-1:0] rinc(input logic [RW-1:0] x);
      return (x == RLAST) ? '0 : x + 1'b1;
   endfunction
   function automatic logic [RW-1:0] rdec(input logic [RW-1:0] x);
      return (x == '0) ? RLAST : x - 1'b1;
   endfunction

   function automatic logic [31:0] shift_v(input logic [31:0] x, input logic [31:0] y);
      logic [31:0] cnt;
      logic [31:0] r;
      cnt = 32'd0 - y;
      if (y[31]) begin
         r = (cnt >= 32'd32) ? 32'd0 : (x << cnt[4:0]);
      end else if (y >= 32'd32) begin
         r = x[31] ? 32'hFFFF_FFFF : 32'd0;
      end else begin
         r = $unsigned($signed(x) >>> y[4:0]);
      end
      return r;
   endfunction

   state_type        state_ff;
   logic [CW-1:0]    clr_ff;
   logic [DW-1:0]    dti_ff;
   logic [RW-1:0]    rti_ff;
   logic [31:0]      ip_ff;
   logic [31:0]      bw_ff;
   logic [1:0]       slot_ff;
   logic             halt_ff;
   dsb_pkg::cmd_type cmd_ff;
   logic [7:0]       oc_ff;
   logic             ov_ff;
   logic             it_ff;
   plan_type         plan_ff;
   plan_type         plan_in;

   logic [31:0] image_mem [MEM_WORDS];
   logic [31:0] dstk [DATA_DEPTH];
   logic [31:0] rstk [RET_DEPTH];
   logic [31:0] mq_ff;
   logic        mzero_ff;
   logic [31:0] t_ff;
   logic [31:0] n_ff;
   logic [31:0] r_ff;

   logic [DW-1:0] nos;
   logic [DW-1:0] up;
   logic [DW-1:0] nn;
   logic [RW-1:0] rup;
   logic [RW-1:0] rdn;
   logic [7:0]    op;
   logic [31:0]   mval;
   logic [31:0]   adv_ip;
   logic [31:0]   cmd_a32;
   logic [31:0]   binv;

   logic [31:0]   mra32;
   logic [AW-1:0] mem_wa;
   logic [31:0]   mem_wd;
   logic          mem_we;
   logic [DW-1:0] dwa;
   logic [31:0]   dwd;
   logic          dwe;
   logic [RW-1:0] rwa;
   logic [31:0]   rwd;
   logic          rwe;
   logic          clr_mem;
   logic          clr_dat;
   logic          clr_ret;

   logic        div_start;
   logic        div_done;
   logic [31:0] div_q;
   logic [31:0] div_r;

   assign nos     = ddec(dti_ff);
   assign up      = dinc(dti_ff);
   assign nn      = ddec(nos);
   assign rup     = rinc(rti_ff);
   assign rdn     = rdec(rti_ff);
   assign op      = 8'(bw_ff >> {slot_ff, 3'b000});
   assign mval    = mzero_ff ? 32'd0 : mq_ff;
   assign adv_ip  = (rti_ff == '0) ? MW : ip_ff + 32'd1;
   assign cmd_a32 = {16'd0, cmd_ff.addr};

   assign clr_mem = (state_ff == S_CLEAR) && ({1'b0, clr_ff} < (CW + 1)'(MEM_WORDS));
   assign clr_dat = (state_ff == S_CLEAR) && ({1'b0, clr_ff} < (CW + 1)'(DATA_DEPTH));
   assign clr_ret = (state_ff == S_CLEAR) && ({1'b0, clr_ff} < (CW + 1)'(RET_DEPTH));

   assign div_start = (state_ff == S_RD) && (op == dsb_pkg::OP_DIVMOD) && (t_ff != 32'd0)
                      && !((t_ff == 32'hFFFF_FFFF) && (n_ff == 32'h8000_0000));

   dsb_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (n_ff),
      .divisor   (t_ff),
      .done      (div_done),
      .quotient  (div_q),
      .remainder (div_r)
   );

   // Image memory port selection.
   always_comb begin
      case (state_ff)
         S_RD:    mra32 = (op == dsb_pkg::OP_LIT) ? ip_ff + 32'd1 : t_ff;
         S_ADV:   mra32 = adv_ip;
         S_DISP:  mra32 = cmd_a32;
         default: mra32 = 32'd0;
      endcase
      mem_we = 1'b0;
      mem_wa = '0;
      mem_wd = 32'd0;
      if (clr_mem) begin
         mem_we = 1'b1;
         mem_wa = clr_ff[AW-1:0];
      end else if (state_ff == S_DISP && cmd_ff.kind == dsb_pkg::KIND_LOAD && cmd_a32 < MW) begin
         mem_we = 1'b1;
         mem_wa = cmd_a32[AW-1:0];
         mem_wd = cmd_ff.value;
      end else if (state_ff == S_WR0 && plan_ff.mw_en) begin
         mem_we = 1'b1;
         mem_wa = plan_ff.mw_a;
         mem_wd = plan_ff.mw_d;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         image_mem[mem_wa] <= mem_wd;
      end
      mq_ff    <= image_mem[mra32[AW-1:0]];
      mzero_ff <= !(mra32 < MW);
   end

   // Stack port selection.
   always_comb begin
      dwe = 1'b0;
      dwa = '0;
      dwd = 32'd0;
      rwe = 1'b0;
      rwa = '0;
      rwd = 32'd0;
      if (clr_dat) begin
         dwe = 1'b1;
         dwa = clr_ff[DW-1:0];
      end else if (state_ff == S_WR0 && plan_ff.w0_en) begin
         dwe = 1'b1;
         dwa = plan_ff.w0_a;
         dwd = plan_ff.w0_d;
      end else if (state_ff == S_WR1 && plan_ff.w1_en) begin
         dwe = 1'b1;
         dwa = plan_ff.w1_a;
         dwd = plan_ff.w1_d;
      end
      if (clr_ret) begin
         rwe = 1'b1;
         rwa = clr_ff[RW-1:0];
      end else if (state_ff == S_WR0 && plan_ff.rw_en) begin
         rwe = 1'b1;
         rwa = plan_ff.rw_a;
         rwd = plan_ff.rw_d;
      end
   end

   always_ff @(posedge clock) begin
      if (dwe) begin
         dstk[dwa] <= dwd;
      end
      t_ff <= dstk[dti_ff];
      n_ff <= dstk[nos];
   end

   always_ff @(posedge clock) begin
      if (rwe) begin
         rstk[rwa] <= rwd;
      end
      r_ff <= rstk[rti_ff];
   end

   always_comb begin
      case (op)
         dsb_pkg::OP_EQ:    binv = (n_ff == t_ff) ? 32'hFFFF_FFFF : 32'd0;
         dsb_pkg::OP_NEQ:   binv = (n_ff != t_ff) ? 32'hFFFF_FFFF : 32'd0;
         dsb_pkg::OP_LT:    binv = ($signed(n_ff) < $signed(t_ff)) ? 32'hFFFF_FFFF : 32'd0;
         dsb_pkg::OP_GT:    binv = ($signed(n_ff) > $signed(t_ff)) ? 32'hFFFF_FFFF : 32'd0;
         dsb_pkg::OP_ADD:   binv = n_ff + t_ff;
         dsb_pkg::OP_SUB:   binv = n_ff - t_ff;
         dsb_pkg::OP_MUL:   binv = n_ff * t_ff;
         dsb_pkg::OP_AND:   binv = n_ff & t_ff;
         dsb_pkg::OP_OR:    binv = n_ff | t_ff;
         dsb_pkg::OP_XOR:   binv = n_ff ^ t_ff;
         dsb_pkg::OP_SHIFT: binv = shift_v(n_ff, t_ff);
         default:           binv = 32'd0;
      endcase
   end

   // Effect of one opcode: pointer updates and the writes still to be made.
   always_comb begin
      plan_in     = '0;
      plan_in.dti = dti_ff;
      plan_in.rti = rti_ff;
      plan_in.ip  = ip_ff;
      case (op)
         dsb_pkg::OP_LIT: begin
            plan_in.ip    = ip_ff + 32'd1;
            plan_in.w0_en = 1'b1;
            plan_in.w0_a  = up;
            plan_in.w0_d  = mval;
            plan_in.dti   = up;
         end
         dsb_pkg::OP_DUP, dsb_pkg::OP_IOENUM, dsb_pkg::OP_POP: begin
            plan_in.w0_en = 1'b1;
            plan_in.w0_a  = up;
            plan_in.dti   = up;
            if (op == dsb_pkg::OP_DUP) begin
               plan_in.w0_d = t_ff;
            end else if (op == dsb_pkg::OP_POP) begin
               plan_in.w0_d = r_ff;
               plan_in.rti  = rdn;
            end else begin
               plan_in.w0_d = 32'd2;
            end
         end
         dsb_pkg::OP_DROP, dsb_pkg::OP_PUSH, dsb_pkg::OP_JUMP, dsb_pkg::OP_CALL: begin
            plan_in.w0_en = 1'b1;
            plan_in.w0_a  = dti_ff;
            plan_in.dti   = nos;
            if (op == dsb_pkg::OP_PUSH) begin
               plan_in.rw_en = 1'b1;
               plan_in.rw_a  = rup;
               plan_in.rw_d  = t_ff;
               plan_in.rti   = rup;
            end else if (op == dsb_pkg::OP_JUMP) begin
               plan_in.ip = t_ff - 32'd1;
            end else if (op == dsb_pkg::OP_CALL) begin
               plan_in.rw_en = 1'b1;
               plan_in.rw_a  = rup;
               plan_in.rw_d  = ip_ff;
               plan_in.rti   = rup;
               plan_in.ip    = t_ff - 32'd1;
            end
            if (dti_ff == '0) begin
               plan_in.ip = MW;
            end
         end
         dsb_pkg::OP_SWAP: begin
            plan_in.w0_en = 1'b1;
            plan_in.w0_a  = dti_ff;
            plan_in.w0_d  = n_ff;
            plan_in.w1_en = 1'b1;
            plan_in.w1_a  = nos;
            plan_in.w1_d  = t_ff;
         end
         dsb_pkg::OP_CCALL: begin
            plan_in.w0_en = 1'b1;
            plan_in.w0_a  = dti_ff;
            plan_in.w1_en = 1'b1;
            plan_in.w1_a  = nos;
            plan_in.dti   = nn;
            if (dti_ff == '0 || nos == '0) begin
               plan_in.ip = MW;
            end
            if (n_ff != 32'd0) begin
               plan_in.rw_en = 1'b1;
               plan_in.rw_a  = rup;
               plan_in.rw_d  = plan_in.ip;
               plan_in.rti   = rup;
               plan_in.ip    = t_ff - 32'd1;
            end
         end
         dsb_pkg::OP_RET: begin
            plan_in.ip  = r_ff;
            plan_in.rti = rdn;
         end
         dsb_pkg::OP_EQ, dsb_pkg::OP_NEQ, dsb_pkg::OP_LT, dsb_pkg::OP_GT,
         dsb_pkg::OP_ADD, dsb_pkg::OP_SUB, dsb_pkg::OP_MUL, dsb_pkg::OP_AND,
         dsb_pkg::OP_OR, dsb_pkg::OP_XOR, dsb_pkg::OP_SHIFT: begin
            plan_in.w0_en = 1'b1;
            plan_in.w0_a  = nos;
            plan_in.w0_d  = binv;
            plan_in.w1_en = 1'b1;
            plan_in.w1_a  = dti_ff;
            plan_in.dti   = nos;
            if (dti_ff == '0) begin
               plan_in.ip = MW;
            end
         end
         dsb_pkg::OP_FETCH: begin
            plan_in.w0_en = 1'b1;
            plan_in.w0_a  = dti_ff;
            case (t_ff)
               32'hFFFF_FFFF: plan_in.w0_d = 32'(dti_ff) - 32'd1;
               32'hFFFF_FFFE: plan_in.w0_d = 32'(rti_ff);
               32'hFFFF_FFFD: plan_in.w0_d = MW;
               32'hFFFF_FFFC: plan_in.w0_d = 32'h8000_0001;
               32'hFFFF_FFFB: plan_in.w0_d = 32'h7FFF_FFFE;
               default:       plan_in.w0_d = mval;
            endcase
         end
         dsb_pkg::OP_STORE: begin
            if (t_ff <= MW) begin
               plan_in.mw_en = (t_ff < MW);
               plan_in.mw_a  = t_ff[AW-1:0];
               plan_in.mw_d  = n_ff;
               plan_in.w0_en = 1'b1;
               plan_in.w0_a  = dti_ff;
               plan_in.w1_en = 1'b1;
               plan_in.w1_a  = nos;
               plan_in.dti   = nn;
               if (dti_ff == '0 || nos == '0) begin
                  plan_in.ip = MW;
               end
            end else begin
               plan_in.ip = MW;
            end
         end
         dsb_pkg::OP_DIVMOD: begin
            plan_in.w0_en = 1'b1;
            plan_in.w0_a  = dti_ff;
            plan_in.w1_a  = nos;
            if (t_ff == 32'd0) begin
               plan_in.w0_d = 32'd0;
            end else if (t_ff == 32'hFFFF_FFFF && n_ff == 32'h8000_0000) begin
               plan_in.w0_d  = 32'h8000_0000;
               plan_in.w1_en = 1'b1;
            end else begin
               plan_in.w0_d  = div_q;
               plan_in.w1_en = 1'b1;
               plan_in.w1_d  = div_r;
            end
         end
         dsb_pkg::OP_ZRET: begin
            if (t_ff == 32'd0) begin
               plan_in.w0_en = 1'b1;
               plan_in.w0_a  = dti_ff;
               plan_in.dti   = nos;
               plan_in.ip    = r_ff;
               plan_in.rti   = rdn;
            end
         end
         dsb_pkg::OP_HALT: begin
            plan_in.ip = MW;
         end
         dsb_pkg::OP_IOQRY: begin
            if (t_ff == 32'd0 || t_ff == 32'd1) begin
               plan_in.w0_en = 1'b1;
               plan_in.w0_a  = dti_ff;
               plan_in.w0_d  = t_ff;
               plan_in.w1_en = 1'b1;
               plan_in.w1_a  = up;
               plan_in.w1_d  = t_ff;
               plan_in.dti   = up;
               if (dti_ff == '0) begin
                  plan_in.ip = MW;
               end
            end
         end
         dsb_pkg::OP_IOACT: begin
            if (t_ff == 32'd1 && cmd_ff.in_eof) begin
               plan_in.eof = 1'b1;
            end else begin
               plan_in.w0_en = 1'b1;
               plan_in.w0_a  = dti_ff;
               if (dti_ff == '0) begin
                  plan_in.ip = MW;
               end
               if (t_ff == 32'd0) begin
                  plan_in.dti = nn;
                  plan_in.oc  = n_ff[7:0];
                  plan_in.ov  = 1'b1;
               end else if (t_ff == 32'd1) begin
                  plan_in.w0_d = {24'd0, cmd_ff.in_char};
                  plan_in.it   = 1'b1;
               end else begin
                  plan_in.dti = nos;
               end
            end
         end
         default: begin
            plan_in.dti = dti_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         dti_ff   <= '0;
         rti_ff   <= '0;
         ip_ff    <= 32'd0;
         bw_ff    <= 32'd0;
         slot_ff  <= 2'd0;
         halt_ff  <= 1'b1;
      end else begin
         case (state_ff)
            S_CLEAR: begin
               if (clr_ff == CW'(CLR_N - 1)) begin
                  state_ff <= S_IDLE;
               end else begin
                  clr_ff <= clr_ff + 1'b1;
               end
            end
            S_IDLE: begin
               if (cmd_valid) begin
                  cmd_ff   <= cmd;
                  oc_ff    <= 8'd0;
                  ov_ff    <= 1'b0;
                  it_ff    <= 1'b0;
                  state_ff <= S_DISP;
               end
            end
            S_DISP: begin
               case (cmd_ff.kind)
                  dsb_pkg::KIND_START: begin
                     rti_ff  <= RW'(1);
                     ip_ff   <= cmd_a32;
                     slot_ff <= 2'd0;
                     if (cmd_a32 < MW) begin
                        halt_ff  <= 1'b0;
                        state_ff <= S_FETCH;
                     end else begin
                        halt_ff  <= 1'b1;
                        state_ff <= S_EMIT;
                     end
                  end
                  dsb_pkg::KIND_EXEC: state_ff <= halt_ff ? S_EMIT : S_RD;
                  default:            state_ff <= S_EMIT;
               endcase
            end
            S_RD: state_ff <= div_start ? S_DIV : S_EXEC;
            S_DIV: begin
               if (div_done) begin
                  state_ff <= S_EXEC;
               end
            end
            S_EXEC: begin
               plan_ff <= plan_in;
               dti_ff  <= plan_in.dti;
               rti_ff  <= plan_in.rti;
               ip_ff   <= plan_in.ip;
               oc_ff   <= plan_in.oc;
               ov_ff   <= plan_in.ov;
               it_ff   <= plan_in.it;
               if (plan_in.eof) begin
                  halt_ff  <= 1'b1;
                  state_ff <= S_EMIT;
               end else begin
                  state_ff <= S_WR0;
               end
            end
            S_WR0: state_ff <= S_WR1;
            S_WR1: state_ff <= S_ADV;
            S_ADV: begin
               if (slot_ff == 2'd3) begin
                  slot_ff <= 2'd0;
                  ip_ff   <= adv_ip;
                  if (adv_ip < MW) begin
                     state_ff <= S_FETCH;
                  end else begin
                     halt_ff  <= 1'b1;
                     state_ff <= S_EMIT;
                  end
               end else begin
                  slot_ff  <= slot_ff + 2'd1;
                  state_ff <= S_EMIT;
               end
            end
            S_FETCH: begin
               bw_ff    <= mval;
               state_ff <= S_EMIT;
            end
            S_EMIT: begin
               if (rsp_space) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign cmd_pop      = (state_ff == S_IDLE) && cmd_valid;
   assign rsp_push     = (state_ff == S_EMIT) && rsp_space;
   assign clearing     = (state_ff == S_CLEAR);
   assign rsp.out_char  = oc_ff;
   assign rsp.out_valid = ov_ff;
   assign rsp.in_taken  = it_ff;
   assign rsp.halted    = halt_ff;
   assign rsp.pc        = dsb_pkg::pc_clamp(ip_ff);

   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> (!cmd_pop && !rsp_push))
      else $error("request or result moved during the clearing pass");

   a_push_space: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> rsp_space)
      else $error("result pushed into a full queue");

   a_push_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_push |=> (state_ff == S_IDLE))
      else $error("sequencer did not return to idle after a result");

   a_div_wait: assert property (@(posedge clock) disable iff (reset)
      div_start |=> (state_ff == S_DIV))
      else $error("divider started without the sequencer waiting on it");

endmodule

// ----- rtl/core/dual_stack_bundle_cpu_unit.sv -----
// Top level of the dual-stack bundle processor: front end, back end, result queue.
// Depends on dsb_pkg, dsb_front and dsb_back.
//
//  channel   handshake        payload
//  request   push / full      req_mode req_addr req_value req_in_char req_in_eof
//  result    empty / pop      rsp_out_char rsp_out_valid rsp_in_taken rsp_halted rsp_pc
//
// A load is written at dispatch, a start also fetches its first word, and an execute
// slot reads, executes, passes both write states and advances, fetching the next word when
// it ends the word; a divide waits on the bit-serial divider. After reset a clearing pass
// zeroes every word of the memory and stacks while full stays high.
// Two requests and two results are queued, so either side may stall independently.
module dual_stack_bundle_cpu_unit #(
   parameter int MEM_WORDS  = dsb_pkg::MEM_WORDS_DEF,
   parameter int DATA_DEPTH = dsb_pkg::DATA_DEPTH_DEF,
   parameter int RET_DEPTH  = dsb_pkg::RET_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  logic [1:0]         req_mode,
   input  logic [15:0]        req_addr,
   input  logic signed [31:0] req_value,
   input  logic [7:0]         req_in_char,
   input  logic               req_in_eof,
   output logic               empty,
   input  logic               pop,
   output logic [7:0]         rsp_out_char,
   output logic               rsp_out_valid,
   output logic               rsp_in_taken,
   output logic               rsp_halted,
   output logic [16:0]        rsp_pc
);

   logic             cmd_valid;
   dsb_pkg::cmd_type cmd;
   logic             cmd_pop;
   logic             rsp_space;
   logic             rsp_push;
   dsb_pkg::rsp_type rsp;
   logic             clearing;

   dsb_pkg::rsp_type oq_ff [2];
   logic             owp_ff;
   logic             orp_ff;
   logic [1:0]       ocnt_ff;
   logic             out_take;

   dsb_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .hold      (clearing),
      .mode      (req_mode),
      .addr      (req_addr),
      .value     ($unsigned(req_value)),
      .in_char   (req_in_char),
      .in_eof    (req_in_eof),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   dsb_back #(
      .MEM_WORDS  (MEM_WORDS),
      .DATA_DEPTH (DATA_DEPTH),
      .RET_DEPTH  (RET_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_space (rsp_space),
      .rsp_push  (rsp_push),
      .rsp       (rsp),
      .clearing  (clearing)
   );

   assign rsp_space = (ocnt_ff != 2'd2);
   assign empty     = (ocnt_ff == 2'd0);
   assign out_take  = pop && !empty;

   always_ff @(posedge clock) begin
      if (rsp_push) begin
         oq_ff[owp_ff] <= rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         owp_ff  <= 1'b0;
         orp_ff  <= 1'b0;
         ocnt_ff <= 2'd0;
      end else begin
         if (rsp_push) begin
            owp_ff <= ~owp_ff;
         end
         if (out_take) begin
            orp_ff <= ~orp_ff;
         end
         case ({rsp_push, out_take})
            2'b10:   ocnt_ff <= ocnt_ff + 2'd1;
            2'b01:   ocnt_ff <= ocnt_ff - 2'd1;
            default: ocnt_ff <= ocnt_ff;
         endcase
      end
   end

   assign rsp_out_char  = oq_ff[orp_ff].out_char;
   assign rsp_out_valid = oq_ff[orp_ff].out_valid;
   assign rsp_in_taken  = oq_ff[orp_ff].in_taken;
   assign rsp_halted    = oq_ff[orp_ff].halted;
   assign rsp_pc        = oq_ff[orp_ff].pc;

endmodule

// ----- tb/dsb_result_checker.sv -----
// Checker for the dual-stack bundle processor: watches both channels, predicts each result
// from its own model of the machine and compares it field by field with what comes out.
// Depends on dsb_pkg.
module dsb_result_checker
   import dsb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  logic        full,
   input  logic [1:0]  req_mode,
   input  logic [15:0] req_addr,
   input  logic [31:0] req_value,
   input  logic [7:0]  req_in_char,
   input  logic        req_in_eof,
   input  logic        empty,
   input  logic        pop,
   input  logic [7:0]  rsp_out_char,
   input  logic        rsp_out_valid,
   input  logic        rsp_in_taken,
   input  logic        rsp_halted,
   input  logic [16:0] rsp_pc,
   output int          fail_count,
   output int          pending,
   output int          checked
);

   localparam logic [31:0] MEM_TOP = 32'd65536;

   logic [31:0] image_mem [65536];
   logic [31:0] data_stk [256];
   logic [31:0] ret_stk [256];
   logic [7:0]  data_top;
   logic [7:0]  ret_top;
   logic [31:0] ip;
   logic [31:0] bundle;
   logic [1:0]  slot;
   logic        stopped;
   rsp_type     expected_results [$];
   int          fails;
   int          compared;

   function automatic logic [31:0] mem_word(input logic [31:0] a);
      return (a < MEM_TOP) ? image_mem[a[15:0]] : 32'd0;
   endfunction

   function automatic void data_push(input logic [31:0] v);
      data_top = data_top + 8'd1;
      data_stk[data_top] = v;
   endfunction

   function automatic logic [31:0] data_pop();
      logic [31:0] v;
      v = data_stk[data_top];
      data_top = data_top - 8'd1;
      return v;
   endfunction

   function automatic void data_drop();
      data_stk[data_top] = '0;
      if (data_top == 8'd0) begin
         ip = MEM_TOP;
      end
      data_top = data_top - 8'd1;
   endfunction

   function automatic void ret_push(input logic [31:0] v);
      ret_top = ret_top + 8'd1;
      ret_stk[ret_top] = v;
   endfunction

   function automatic logic [31:0] ret_pop();
      logic [31:0] v;
      v = ret_stk[ret_top];
      ret_top = ret_top - 8'd1;
      return v;
   endfunction

   function automatic void fold(input logic [31:0] v);
      data_stk[data_top - 8'd1] = v;
      data_drop();
   endfunction

   function automatic logic [31:0] shifted(input logic [31:0] x, input logic [31:0] y);
      logic [31:0] cnt;
      if (y[31]) begin
         cnt = 32'd0 - y;
         return (cnt >= 32) ? 32'd0 : x << cnt;
      end
      if (y >= 32) begin
         return x[31] ? 32'hFFFF_FFFF : 32'd0;
      end
      return $signed(x) >>> y;
   endfunction

   // Returns 0 when a character read meets the end of input.
   function automatic bit run_slot(input logic [7:0] op, input logic [7:0] ch, input logic eof,
                                   inout rsp_type r);
      logic [31:0] t, n, a, b;
      t = data_stk[data_top];
      n = data_stk[data_top - 8'd1];
      case (op)
         OP_LIT: begin
            ip = ip + 1;
            data_push(mem_word(ip));
         end
         OP_DUP:  data_push(t);
         OP_DROP: data_drop();
         OP_SWAP: begin
            data_stk[data_top] = n;
            data_stk[data_top - 8'd1] = t;
         end
         OP_PUSH: begin
            ret_push(t);
            data_drop();
         end
         OP_POP: begin
            data_push(ret_stk[ret_top]);
            ret_top = ret_top - 8'd1;
         end
         OP_JUMP: begin
            ip = t - 1;
            data_drop();
         end
         OP_CALL: begin
            ret_push(ip);
            ip = t - 1;
            data_drop();
         end
         OP_CCALL: begin
            a = t;
            data_drop();
            b = data_stk[data_top];
            data_drop();
            if (b != 0) begin
               ret_push(ip);
               ip = a - 1;
            end
         end
         OP_RET: ip = ret_pop();
         OP_EQ:  fold((n == t) ? 32'hFFFF_FFFF : 32'd0);
         OP_NEQ: fold((n != t) ? 32'hFFFF_FFFF : 32'd0);
         OP_LT:  fold(($signed(n) < $signed(t)) ? 32'hFFFF_FFFF : 32'd0);
         OP_GT:  fold(($signed(n) > $signed(t)) ? 32'hFFFF_FFFF : 32'd0);
         OP_FETCH: begin
            case ($signed(t))
               -1:      data_stk[data_top] = 32'(data_top) - 32'd1;
               -2:      data_stk[data_top] = 32'(ret_top);
               -3:      data_stk[data_top] = MEM_TOP;
               -4:      data_stk[data_top] = 32'h8000_0001;
               -5:      data_stk[data_top] = 32'h7FFF_FFFE;
               default: data_stk[data_top] = mem_word(t);
            endcase
         end
         OP_STORE: begin
            if (t <= MEM_TOP) begin
               if (t < MEM_TOP) begin
                  image_mem[t[15:0]] = n;
               end
               data_drop();
               data_drop();
            end else begin
               ip = MEM_TOP;
            end
         end
         OP_ADD: fold(n + t);
         OP_SUB: fold(n - t);
         OP_MUL: fold(n * t);
         OP_DIVMOD: begin
            if (t == 0) begin
               data_stk[data_top] = '0;
            end else if (t == 32'hFFFF_FFFF && n == 32'h8000_0000) begin
               data_stk[data_top] = 32'h8000_0000;
               data_stk[data_top - 8'd1] = '0;
            end else begin
               data_stk[data_top] = $signed(n) / $signed(t);
               data_stk[data_top - 8'd1] = $signed(n) % $signed(t);
            end
         end
         OP_AND:   fold(t & n);
         OP_OR:    fold(t | n);
         OP_XOR:   fold(t ^ n);
         OP_SHIFT: fold(shifted(n, t));
         OP_ZRET: begin
            if (t == 0) begin
               data_drop();
               ip = ret_pop();
            end
         end
         OP_HALT:   ip = MEM_TOP;
         OP_IOENUM: data_push(32'd2);
         OP_IOQRY: begin
            if (t == 0 || t == 1) begin
               data_drop();
               data_push(t);
               data_push(t);
            end
         end
         OP_IOACT: begin
            if (t == 0) begin
               data_drop();
               r.out_char = 8'(data_pop());
               r.out_valid = 1'b1;
            end else if (t == 1) begin
               if (eof) begin
                  return 1'b0;
               end
               data_drop();
               data_push(32'(ch));
               r.in_taken = 1'b1;
            end else begin
               data_drop();
            end
         end
         default: ;
      endcase
      return 1'b1;
   endfunction

   function automatic rsp_type apply_request();
      rsp_type r;
      r = '0;
      if (req_mode == KIND_LOAD) begin
         image_mem[req_addr] = req_value;
      end else if (req_mode == KIND_START) begin
         ret_top = 8'd1;
         ip = 32'(req_addr);
         slot = 2'd0;
         stopped = 1'b0;
         bundle = image_mem[req_addr];
      end else if (req_mode == KIND_EXEC && !stopped) begin
         if (!run_slot(bundle[8 * slot +: 8], req_in_char, req_in_eof, r)) begin
            stopped = 1'b1;
         end else if (slot == 2'd3) begin
            slot = 2'd0;
            ip = ip + 1;
            if (ret_top == 8'd0) begin
               ip = MEM_TOP;
            end
            if (ip < MEM_TOP) begin
               bundle = image_mem[ip[15:0]];
            end else begin
               stopped = 1'b1;
            end
         end else begin
            slot = slot + 2'd1;
         end
      end
      r.halted = stopped;
      if (ip[31]) begin
         r.pc = '0;
      end else if (ip > MEM_TOP) begin
         r.pc = 17'h1_0000;
      end else begin
         r.pc = ip[16:0];
      end
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
         fails++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         foreach (image_mem[i]) image_mem[i] = '0;
         foreach (data_stk[i]) data_stk[i] = '0;
         foreach (ret_stk[i]) ret_stk[i] = '0;
         data_top = '0;
         ret_top = '0;
         ip = '0;
         bundle = '0;
         slot = '0;
         stopped = 1'b1;
         expected_results.delete();
         fails = 0;
         compared = 0;
      end else begin
         if (pop && !empty) begin
            if (expected_results.size() == 0) begin
               $display("%0t: result with nothing expected, expected none, got pc %0h",
                        $time, rsp_pc);
               fails++;
            end else begin
               want = expected_results.pop_front();
               check_field("out_char", want.out_char, rsp_out_char);
               check_field("out_valid", want.out_valid, rsp_out_valid);
               check_field("in_taken", want.in_taken, rsp_in_taken);
               check_field("halted", want.halted, rsp_halted);
               check_field("pc", want.pc, rsp_pc);
               compared++;
            end
         end
         if (push && !full) begin
            expected_results.push_back(apply_request());
         end
      end
      fail_count <= fails;
      pending <= expected_results.size();
      checked <= compared;
   end

endmodule

// ----- tb/tb_dual_stack_bundle_cpu_unit.sv -----
// Testbench top for the dual-stack bundle processor: drives directed and random programs
// under varying handshake pressure and gives the verdict.
// Depends on dsb_pkg, dual_stack_bundle_cpu_unit and dsb_result_checker.
module tb_dual_stack_bundle_cpu_unit;
   import dsb_pkg::*;

   localparam int ITEM_TARGET = 1950;
   localparam int STALL_LIMIT = 300000;

   logic        clock;
   logic        reset;
   logic        push;
   logic        full;
   logic [1:0]  req_mode;
   logic [15:0] req_addr;
   logic [31:0] req_value;
   logic [7:0]  req_in_char;
   logic        req_in_eof;
   logic        empty;
   logic        pop;
   logic [7:0]  rsp_out_char;
   logic        rsp_out_valid;
   logic        rsp_in_taken;
   logic        rsp_halted;
   logic [16:0] rsp_pc;
   int          fail_count;
   int          pending;
   int          checked;
   int          sent;
   int          send_pct;
   int          recv_pct;
   int          stall_cycles;

   dual_stack_bundle_cpu_unit DUT (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .req_mode(req_mode), .req_addr(req_addr), .req_value(req_value),
      .req_in_char(req_in_char), .req_in_eof(req_in_eof),
      .empty(empty), .pop(pop), .rsp_out_char(rsp_out_char),
      .rsp_out_valid(rsp_out_valid), .rsp_in_taken(rsp_in_taken),
      .rsp_halted(rsp_halted), .rsp_pc(rsp_pc)
   );

   dsb_result_checker u_checker (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .req_mode(req_mode), .req_addr(req_addr), .req_value(req_value),
      .req_in_char(req_in_char), .req_in_eof(req_in_eof),
      .empty(empty), .pop(pop), .rsp_out_char(rsp_out_char),
      .rsp_out_valid(rsp_out_valid), .rsp_in_taken(rsp_in_taken),
      .rsp_halted(rsp_halted), .rsp_pc(rsp_pc),
      .fail_count(fail_count), .pending(pending), .checked(checked)
   );

   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         pop <= ($urandom_range(99) >= recv_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   function automatic logic [31:0] pack_ops(input logic [7:0] s0, input logic [7:0] s1,
                                            input logic [7:0] s2, input logic [7:0] s3);
      return {s3, s2, s1, s0};
   endfunction

   task automatic send(input kind_type kind, input logic [15:0] addr, input logic [31:0] value,
                       input logic [7:0] ch, input logic eof);
      if (sent == ITEM_TARGET / 4) begin
         send_pct = 66;
      end else if (sent == ITEM_TARGET / 2) begin
         send_pct = 0;
         recv_pct = 66;
      end else if (sent == 3 * ITEM_TARGET / 4) begin
         send_pct = 7;
         recv_pct = 7;
      end
      if ($urandom_range(99) < send_pct) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      push <= 1'b1;
      req_mode <= kind;
      req_addr <= addr;
      req_value <= value;
      req_in_char <= ch;
      req_in_eof <= eof;
      @(posedge clock);
      while (full) @(posedge clock);
      sent++;
   endtask

   task automatic exec(input logic eof);
      send(KIND_EXEC, 16'($urandom), $urandom, 8'($urandom), eof);
   endtask

   function automatic logic [31:0] random_word();
      logic [7:0] ops [4];
      case ($urandom_range(7))
         0:       return $urandom;
         1, 2:    return $urandom_range(0, 300);
         3: begin
            case ($urandom_range(3))
               0:       return 32'd65536;
               1:       return 32'd65537;
               2:       return 32'h8000_0000;
               default: return 32'd0 - $urandom_range(1, 5);
            endcase
         end
         default: begin
            foreach (ops[i]) begin
               ops[i] = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 29));
            end
            return pack_ops(ops[0], ops[1], ops[2], ops[3]);
         end
      endcase
   endfunction

   task automatic random_program();
      int base;
      int words;
      int steps;
      base = $urandom_range(0, 250);
      words = $urandom_range(3, 10);
      for (int i = 0; i < words; i++) begin
         send(KIND_LOAD, 16'(base + i), random_word(), 8'($urandom), 1'($urandom));
      end
      send(KIND_START, 16'(base), $urandom, 8'($urandom), 1'($urandom));
      steps = $urandom_range(10, 50);
      for (int i = 0; i < steps; i++) begin
         if ($urandom_range(14) == 0) begin
            send(kind_type'($urandom_range(0, 3)), 16'($urandom), $urandom, 8'($urandom),
                 1'($urandom));
         end else begin
            exec($urandom_range(11) == 0);
         end
      end
   endtask

   initial begin
      reset <= 1'b1;
      push <= 1'b0;
      req_mode <= KIND_LOAD;
      req_addr <= '0;
      req_value <= '0;
      req_in_char <= '0;
      req_in_eof <= 1'b0;
      sent = 0;
      send_pct = 0;
      recv_pct = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      send(KIND_LOAD, 16'hFFFF, 32'h7FFF_FFFF, 8'hFF, 1'b1);
      send(KIND_LOAD, 16'h0000, 32'h8000_0000, 8'h00, 1'b0);
      send(KIND_NONE, 16'h1234, 32'hFFFF_FFFF, 8'hA5, 1'b0);
      exec(1'b0);
      send(KIND_LOAD, 16'd16, pack_ops(OP_LIT, OP_LIT, OP_DIVMOD, OP_LIT), 8'd0, 1'b0);
      send(KIND_LOAD, 16'd17, 32'h8000_0000, 8'd0, 1'b0);
      send(KIND_LOAD, 16'd18, 32'hFFFF_FFFF, 8'd0, 1'b0);
      send(KIND_LOAD, 16'd19, 32'd0, 8'd0, 1'b0);
      send(KIND_LOAD, 16'd20, pack_ops(OP_DIVMOD, OP_LIT, OP_FETCH, OP_LIT), 8'd0, 1'b0);
      send(KIND_LOAD, 16'd21, 32'hFFFF_FFFD, 8'd0, 1'b0);
      send(KIND_LOAD, 16'd22, 32'd65536, 8'd0, 1'b0);
      send(KIND_LOAD, 16'd23, pack_ops(OP_STORE, OP_LIT, OP_SHIFT, OP_LIT), 8'd0, 1'b0);
      send(KIND_LOAD, 16'd24, 32'hFFFF_FFF0, 8'd0, 1'b0);
      send(KIND_LOAD, 16'd25, 32'd1, 8'd0, 1'b0);
      send(KIND_LOAD, 16'd26, pack_ops(OP_IOACT, OP_HALT, 8'd0, 8'd0), 8'd0, 1'b0);
      send(KIND_START, 16'd16, 32'd0, 8'd0, 1'b0);
      repeat (12) exec(1'b0);
      exec(1'b1);

      while (sent < ITEM_TARGET) random_program();
      push <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);

      $display("Ran %0d requests of loads, starts and execute slots; %0d results compared.",
               sent, checked);
      $display("Covered free flow, sender gaps, receiver stalls and light pressure on both.");
      if (fail_count == 0 && pending == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
